### hw/rtl/urlpd_pkg.sv
// ----------------------------------------------------------------------------
// urlpd_pkg: shared types and constants of the URL percent decoder
// Holds the escape phase and status codes, and the decoder state and result
// structs passed between the top level and the decode step.
// ----------------------------------------------------------------------------
package urlpd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned NibW  = 4;

  // Escape phase: which kind of byte comes next.
  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_HEX_HI = 2'd1,
    PH_HEX_LO = 2'd2
  } phase_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_ESC  = 2'd1,
    ST_UNEXPECT = 2'd2
  } status_t;

  localparam logic [ByteW-1:0] CH_DASH    = 8'h2D;
  localparam logic [ByteW-1:0] CH_UNDER   = 8'h5F;
  localparam logic [ByteW-1:0] CH_DOT     = 8'h2E;
  localparam logic [ByteW-1:0] CH_TILDE   = 8'h7E;
  localparam logic [ByteW-1:0] CH_STAR    = 8'h2A;
  localparam logic [ByteW-1:0] CH_PLUS    = 8'h2B;
  localparam logic [ByteW-1:0] CH_PERCENT = 8'h25;
  localparam logic [ByteW-1:0] CH_SPACE   = 8'h20;

  typedef struct packed {
    phase_t          phase;
    logic [NibW-1:0] high_nibble;
    logic            discarding;
  } dec_state_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    status_t          status;
    logic             last;
  } dec_result_t;

  localparam dec_state_t STATE_RESET = '{phase: PH_NORMAL, high_nibble: '0, discarding: 1'b0};

endpackage

### hw/rtl/urlpd_step.sv
// ----------------------------------------------------------------------------
// urlpd_step: one decode step of the URL percent decoder
// Combinational: takes the current state and one byte, gives the next state
// and zero or one result.
// ----------------------------------------------------------------------------
module urlpd_step
  import urlpd_pkg::*;
(
  input  dec_state_t       state_i,
  input  logic [ByteW-1:0] byte_i,
  input  logic             last_i,
  output dec_state_t       state_o,
  output dec_result_t      result_o
);

  logic            hex_ok;
  logic [NibW-1:0] hex_val;
  logic            pass_ok;

  // Hex digit value, either case.
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = '0;
    if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
      hex_val = byte_i[NibW-1:0];
    end else if ((byte_i >= 8'h41 && byte_i <= 8'h46) ||
                 (byte_i >= 8'h61 && byte_i <= 8'h66)) begin
      hex_val = byte_i[NibW-1:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign pass_ok = (byte_i >= 8'h30 && byte_i <= 8'h39) ||
                   (byte_i >= 8'h41 && byte_i <= 8'h5A) ||
                   (byte_i >= 8'h61 && byte_i <= 8'h7A) ||
                   byte_i == CH_DASH || byte_i == CH_UNDER || byte_i == CH_DOT ||
                   byte_i == CH_TILDE || byte_i == CH_STAR;

  always_comb begin
    state_o  = state_i;
    result_o = '{valid: 1'b0, data: '0, status: ST_OK, last: 1'b0};
    if (state_i.discarding) begin
      if (last_i) begin
        state_o = STATE_RESET;
      end
    end else begin
      unique case (state_i.phase)
        PH_HEX_HI: begin
          if (!hex_ok || last_i) begin
            state_o  = '{phase: PH_NORMAL, high_nibble: '0, discarding: !last_i};
            result_o = '{valid: 1'b1, data: '0, status: ST_BAD_ESC, last: 1'b1};
          end else begin
            state_o.phase       = PH_HEX_LO;
            state_o.high_nibble = hex_val;
          end
        end
        PH_HEX_LO: begin
          if (!hex_ok) begin
            state_o  = '{phase: PH_NORMAL, high_nibble: '0, discarding: !last_i};
            result_o = '{valid: 1'b1, data: '0, status: ST_BAD_ESC, last: 1'b1};
          end else begin
            state_o  = STATE_RESET;
            result_o = '{valid: 1'b1, data: {state_i.high_nibble, hex_val},
                         status: ST_OK, last: last_i};
          end
        end
        default: begin
          // Normal byte; the unused phase code behaves the same.
          state_o.phase = PH_NORMAL;
          if (pass_ok) begin
            result_o = '{valid: 1'b1, data: byte_i, status: ST_OK, last: last_i};
          end else if (byte_i == CH_PLUS) begin
            result_o = '{valid: 1'b1, data: CH_SPACE, status: ST_OK, last: last_i};
          end else if (byte_i == CH_PERCENT && !last_i) begin
            state_o.phase = PH_HEX_HI;
          end else if (byte_i == CH_PERCENT) begin
            state_o  = STATE_RESET;
            result_o = '{valid: 1'b1, data: '0, status: ST_BAD_ESC, last: 1'b1};
          end else begin
            state_o  = '{phase: PH_NORMAL, high_nibble: '0, discarding: !last_i};
            result_o = '{valid: 1'b1, data: '0, status: ST_UNEXPECT, last: 1'b1};
          end
        end
      endcase
    end
  end

endmodule

### hw/rtl/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder: form-urlencoded percent decoder, one byte per beat
// Streams an encoded string in and decoded bytes with a status code out.
// ----------------------------------------------------------------------------
// The decoder takes one encoded byte per beat on the in_ channel, with in_tlast
// on each string's final byte, and sustains one byte per clock unless stalled.
// A byte is held in an input register, decoded by a single combinational step
// (hex digit check, pass-through check, escape phase update) and lands in the
// output register, from which it is offered on the out_ channel.
// Letters, digits and - _ . ~ * pass unchanged, + becomes a space and %XX
// becomes one byte; a percent sign and the first hex digit give no beat.
// out_tuser carries the status: 0 ok, 1 bad or truncated escape, 2 unexpected
// character. An error beat has data 0 and out_tlast set; the rest of that
// string is then dropped without any beat, and decoding restarts with the
// next string. Backpressure on out_tready stalls the input register and in
// turn in_tready; a byte that gives no result still waits for a free output
// slot before it retires.
module url_percent_decoder
  import urlpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [ByteW-1:0] in_tdata,   // [7:0] in_byte
  input  logic             in_tlast,   // string_end
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [ByteW-1:0] out_tdata,  // [7:0] out_byte
  output logic [1:0]       out_tuser,  // [1:0] status
  output logic             out_tlast   // end_of_string
);

  // Input register
  logic             s1_valid_r, s1_valid_nxt;
  logic [ByteW-1:0] s1_byte_r;
  logic             s1_last_r;

  // Decoder state
  dec_state_t  state_r, state_nxt;
  dec_result_t step_res;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic [ByteW-1:0] out_byte_r;
  status_t          out_status_r;
  logic             out_last_r;

  logic advance;   // the held byte retires this cycle
  logic in_beat;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_beat   = in_tvalid && in_tready;

  urlpd_step u_step (
    .state_i  (state_r),
    .byte_i   (s1_byte_r),
    .last_i   (s1_last_r),
    .state_o  (state_nxt),
    .result_o (step_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_beat) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = step_res.valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload: capture on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (advance && step_res.valid) begin
      out_byte_r   <= step_res.data;
      out_status_r <= step_res.status;
      out_last_r   <= step_res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

### hw/rtl/urlpd_checker.sv
// ----------------------------------------------------------------------------
// urlpd_checker: port-level checks for the URL percent decoder
// Watches the result channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module urlpd_checker
  import urlpd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [ByteW-1:0] out_tdata,
  input logic [1:0]       out_tuser,
  input logic             out_tlast
);

  // No beat right after a reset cycle.
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

  // Status is one of the three defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_BAD_ESC ||
                    out_tuser == ST_UNEXPECT))
    else $error("undefined status code");

  // An error beat carries zero data and closes the string.
  a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == '0 && out_tlast)
    else $error("error beat with data or without end of string");

  // A stalled beat holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result beat changed");

endmodule

bind url_percent_decoder urlpd_checker u_urlpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
